// ----- hdl/brc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and constants for the barometer raw compensation unit.
// ----------------------------------------------------------------------------
package brc_pkg;

   localparam int DivW      = 32;   // divider operand width
   localparam int DivStages = DivW; // one quotient bit per stage
   localparam int TagW      = 58;   // sideband carried through the divider

   localparam logic [31:0] TempOffset  = 32'd4000;
   localparam logic [31:0] XbOffset    = 32'd32768;
   localparam logic [31:0] Corr3038    = 32'd3038;
   localparam logic [31:0] CorrM7357   = 32'hFFFF_E343; // -7357
   localparam logic [31:0] Corr3791    = 32'd3791;

   typedef enum logic [2:0] {
      CSR_OSS     = 3'd0,
      CSR_AC1     = 3'd1,
      CSR_AC2     = 3'd2,
      CSR_AC3     = 3'd3,
      CSR_AC4     = 3'd4,
      CSR_AC5_AC6 = 3'd5,
      CSR_B1_B2   = 3'd6,
      CSR_MC_MD   = 3'd7
   } csr_index_type;

   // 50000 >> oversampling
   function automatic logic [15:0] press_scale(input logic [1:0] oss);
      logic [15:0] base;
      base = 16'd50000;
      return base >> oss;
   endfunction

endpackage

// ----- hdl/brc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband tag and per-stage valid/ready so stalls squeeze bubbles.
// ----------------------------------------------------------------------------
module brc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [brc_pkg::DivW-1:0]  in_dividend,
   input  logic [brc_pkg::DivW-1:0]  in_divisor,
   input  logic [brc_pkg::TagW-1:0]  in_tag,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [brc_pkg::DivW-1:0]  out_quotient,
   output logic [brc_pkg::TagW-1:0]  out_tag
);
   import brc_pkg::*;

   logic [DivW-1:0]      rem_ff [DivStages];
   logic [DivW-1:0]      acc_ff [DivStages];
   logic [DivW-1:0]      dvs_ff [DivStages];
   logic [TagW-1:0]      tag_ff [DivStages];
   logic [DivStages-1:0] v_ff;
   logic [DivStages:0]   rdy;

   assign rdy[DivStages] = out_ready;

   for (genvar g = 0; g < DivStages; g++) begin : g_stage
      logic [DivW-1:0] rem_src, acc_src, dvs_src, rem_in;
      logic [TagW-1:0] tag_src;
      logic            v_src;
      logic [DivW:0]   trial;
      logic            ge;

      if (g == 0) begin : g_first
         assign rem_src = '0;
         assign acc_src = in_dividend;
         assign dvs_src = in_divisor;
         assign tag_src = in_tag;
         assign v_src   = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign acc_src = acc_ff[g-1];
         assign dvs_src = dvs_ff[g-1];
         assign tag_src = tag_ff[g-1];
         assign v_src   = v_ff[g-1];
      end

      assign rdy[g]  = !v_ff[g] || rdy[g+1];
      assign trial   = {rem_src, acc_src[DivW-1]};
      assign ge      = trial >= {1'b0, dvs_src};
      assign rem_in  = ge ? DivW'(trial - {1'b0, dvs_src}) : trial[DivW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (rdy[g]) begin
            v_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g]) begin
            rem_ff[g] <= rem_in;
            acc_ff[g] <= {acc_src[DivW-2:0], ge};
            dvs_ff[g] <= dvs_src;
            tag_ff[g] <= tag_src;
         end
      end
   end

   assign in_ready     = rdy[0];
   assign out_valid    = v_ff[DivStages-1];
   assign out_quotient = acc_ff[DivStages-1];
   assign out_tag      = tag_ff[DivStages-1];

endmodule

// ----- hdl/barometer_raw_compensation_unit.sv -----
`timescale 1ns / 1ps
// Stages: 3 front stages, 32-stage divider for B5, 6 middle stages, 32-stage
//   divider for the pressure, 3 tail, from req beat to rsp beat.
// Throughput: one beat per cycle; a full stage holds while the one after cannot take its beat.
// Reset: synchronous, clears all stage valids and zeroes the calibration set.
// ----------------------------------------------------------------------------
// barometer_raw_compensation_unit
// Integer temperature/pressure compensation chain of a barometric sensor.
// ----------------------------------------------------------------------------
module barometer_raw_compensation_unit (
   input  logic                   clock,
   input  logic                   reset,
   // config write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  brc_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,  // [15:0] raw_temp, [39:16] raw_press_bytes
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,  // [27:0] temperature_decicelsius,
                                              // [59:28] pressure_pa, [63:60] zero
   output logic                   rsp_tuser   // [0] divide_error
);
   import brc_pkg::*;

   // ---------------- calibration registers ----------------
   logic [1:0]  oss_ff;
   logic [15:0] ac1_ff, ac2_ff, ac3_ff, ac4_ff;
   logic [31:0] ac56_ff, b12_ff, mcmd_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff  <= '0;
         ac1_ff  <= '0;
         ac2_ff  <= '0;
         ac3_ff  <= '0;
         ac4_ff  <= '0;
         ac56_ff <= '0;
         b12_ff  <= '0;
         mcmd_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OSS:     oss_ff  <= csr_data[1:0];
            CSR_AC1:     ac1_ff  <= csr_data[15:0];
            CSR_AC2:     ac2_ff  <= csr_data[15:0];
            CSR_AC3:     ac3_ff  <= csr_data[15:0];
            CSR_AC4:     ac4_ff  <= csr_data[15:0];
            CSR_AC5_AC6: ac56_ff <= csr_data;
            CSR_B1_B2:   b12_ff  <= csr_data;
            CSR_MC_MD:   mcmd_ff <= csr_data;
            default:     ;
         endcase
      end
   end

   // sign-extended coefficients
   logic [31:0] ac1_x, ac2_x, ac3_x, b1_x, b2_x, mc_x, md_x;
   logic [15:0] ac5, ac6;
   assign ac1_x = {{16{ac1_ff[15]}}, ac1_ff};
   assign ac2_x = {{16{ac2_ff[15]}}, ac2_ff};
   assign ac3_x = {{16{ac3_ff[15]}}, ac3_ff};
   assign b1_x  = {{16{b12_ff[31]}}, b12_ff[31:16]};
   assign b2_x  = {{16{b12_ff[15]}}, b12_ff[15:0]};
   assign mc_x  = {{16{mcmd_ff[31]}}, mcmd_ff[31:16]};
   assign md_x  = {{16{mcmd_ff[15]}}, mcmd_ff[15:0]};
   assign ac5   = ac56_ff[31:16];
   assign ac6   = ac56_ff[15:0];

   // ---------------- ready chains ----------------
   logic [2:0] va_ff, ra;
   logic [5:0] vb_ff, rb;
   logic [2:0] vc_ff, rc;
   logic       d1_in_ready, d1_out_valid, d2_in_ready, d2_out_valid;

   assign ra[2] = !va_ff[2] || d1_in_ready;
   assign ra[1] = !va_ff[1] || ra[2];
   assign ra[0] = !va_ff[0] || ra[1];
   assign rb[5] = !vb_ff[5] || d2_in_ready;
   for (genvar g = 0; g < 5; g++) begin : g_rb
      assign rb[g] = !vb_ff[g] || rb[g+1];
   end
   assign rc[2] = !vc_ff[2] || rsp_tready;
   assign rc[1] = !vc_ff[1] || rc[2];
   assign rc[0] = !vc_ff[0] || rc[1];

   assign req_tready = ra[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
         vb_ff <= '0;
         vc_ff <= '0;
      end else begin
         if (ra[0]) va_ff[0] <= req_tvalid;
         if (ra[1]) va_ff[1] <= va_ff[0];
         if (ra[2]) va_ff[2] <= va_ff[1];
         if (rb[0]) vb_ff[0] <= d1_out_valid;
         for (int i = 1; i < 6; i++) begin
            if (rb[i]) vb_ff[i] <= vb_ff[i-1];
         end
         if (rc[0]) vc_ff[0] <= d2_out_valid;
         if (rc[1]) vc_ff[1] <= vc_ff[0];
         if (rc[2]) vc_ff[2] <= vc_ff[1];
      end
   end

   // ---------------- A0: capture, oversampling shift ----------------
   logic [15:0] a0_ut_ff;
   logic [23:0] a0_up_ff, a0_up_in;
   assign a0_up_in = req_tdata[39:16] >> (4'd8 - {2'b00, oss_ff});

   always_ff @(posedge clock) begin
      if (ra[0]) begin
         a0_ut_ff <= req_tdata[15:0];
         a0_up_ff <= a0_up_in;
      end
   end

   // ---------------- A1: X1 = ((UT - AC6) * AC5) >> 15 ----------------
   logic [16:0] a1_diff;
   logic [31:0] a1_prod, a1_x1_in, a1_x1_ff;
   logic [23:0] a1_up_ff;
   assign a1_diff  = {1'b0, a0_ut_ff} - {1'b0, ac6};
   assign a1_prod  = {{15{a1_diff[16]}}, a1_diff} * {16'd0, ac5};
   assign a1_x1_in = $signed(a1_prod) >>> 15;

   always_ff @(posedge clock) begin
      if (ra[1]) begin
         a1_x1_ff <= a1_x1_in;
         a1_up_ff <= a0_up_ff;
      end
   end

   // ---------------- A2: operands of MC*2048 / (X1 + MD) ----------------
   logic [31:0] a2_den, a2_num, a2_num_mag_ff, a2_den_mag_ff, a2_x1_ff;
   logic [23:0] a2_up_ff;
   logic        a2_neg_ff, a2_dz_ff;
   assign a2_den = a1_x1_ff + md_x;
   assign a2_num = mc_x << 11;

   always_ff @(posedge clock) begin
      if (ra[2]) begin
         a2_num_mag_ff <= a2_num[31] ? 32'(-a2_num) : a2_num;
         a2_den_mag_ff <= a2_den[31] ? 32'(-a2_den) : a2_den;
         a2_neg_ff     <= a2_num[31] ^ a2_den[31];
         a2_dz_ff      <= a2_den == '0;
         a2_x1_ff      <= a1_x1_ff;
         a2_up_ff      <= a1_up_ff;
      end
   end

   logic [TagW-1:0] d1_tag_in, d1_tag;
   logic [31:0]     d1_quot;
   assign d1_tag_in = {a2_dz_ff, a2_neg_ff, a2_up_ff, a2_x1_ff};

   brc_div u_div_temp (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (va_ff[2]),
      .in_ready     (d1_in_ready),
      .in_dividend  (a2_num_mag_ff),
      .in_divisor   (a2_den_mag_ff),
      .in_tag       (d1_tag_in),
      .out_valid    (d1_out_valid),
      .out_ready    (rb[0]),
      .out_quotient (d1_quot),
      .out_tag      (d1_tag)
   );

   // ---------------- B0: B5, T, B6 ----------------
   logic [31:0] b0_x2, b0_b5, b0_t32, b0_b6_ff;
   logic [27:0] b0_t_ff;
   logic [23:0] b0_up_ff;
   logic        b0_err_ff;
   assign b0_x2  = d1_tag[56] ? 32'(-d1_quot) : d1_quot;
   assign b0_b5  = d1_tag[31:0] + b0_x2;
   assign b0_t32 = $signed(b0_b5 + 32'd8) >>> 4;

   always_ff @(posedge clock) begin
      if (rb[0]) begin
         b0_b6_ff  <= b0_b5 - TempOffset;
         b0_t_ff   <= b0_t32[27:0];
         b0_up_ff  <= d1_tag[55:32];
         b0_err_ff <= d1_tag[57];
      end
   end

   // ---------------- B1: B6^2, AC2*B6, AC3*B6 ----------------
   logic [31:0] b1_sqp, b1_m2, b1_m3, b1_sq_ff, b1_x2a_ff, b1_x1c_ff;
   logic [27:0] b1_t_ff;
   logic [23:0] b1_up_ff;
   logic        b1_err_ff;
   assign b1_sqp = b0_b6_ff * b0_b6_ff;
   assign b1_m2  = ac2_x * b0_b6_ff;
   assign b1_m3  = ac3_x * b0_b6_ff;

   always_ff @(posedge clock) begin
      if (rb[1]) begin
         b1_sq_ff  <= $signed(b1_sqp) >>> 12;
         b1_x2a_ff <= $signed(b1_m2) >>> 11;
         b1_x1c_ff <= $signed(b1_m3) >>> 13;
         b1_t_ff   <= b0_t_ff;
         b1_up_ff  <= b0_up_ff;
         b1_err_ff <= b0_err_ff;
      end
   end

   // ---------------- B2: B2*sq, B1*sq ----------------
   logic [31:0] b2_mb2, b2_mb1, b2_x1a_ff, b2_x2c_ff, b2_x2a_ff, b2_x1c_ff;
   logic [27:0] b2_t_ff;
   logic [23:0] b2_up_ff;
   logic        b2_err_ff;
   assign b2_mb2 = b2_x * b1_sq_ff;
   assign b2_mb1 = b1_x * b1_sq_ff;

   always_ff @(posedge clock) begin
      if (rb[2]) begin
         b2_x1a_ff <= $signed(b2_mb2) >>> 11;
         b2_x2c_ff <= $signed(b2_mb1) >>> 16;
         b2_x2a_ff <= b1_x2a_ff;
         b2_x1c_ff <= b1_x1c_ff;
         b2_t_ff   <= b1_t_ff;
         b2_up_ff  <= b1_up_ff;
         b2_err_ff <= b1_err_ff;
      end
   end

   // ---------------- B3: raw B3, X3 of the B4 path ----------------
   logic [31:0] b3_x3, b3_sum, b3_b3raw_ff, b3_x3c_ff;
   logic [27:0] b3_t_ff;
   logic [23:0] b3_up_ff;
   logic        b3_err_ff;
   assign b3_x3  = b2_x1a_ff + b2_x2a_ff;
   assign b3_sum = b2_x1c_ff + b2_x2c_ff + 32'd2;

   always_ff @(posedge clock) begin
      if (rb[3]) begin
         b3_b3raw_ff <= (ac1_x << 2) + b3_x3;
         b3_x3c_ff   <= $signed(b3_sum) >>> 2;
         b3_t_ff     <= b2_t_ff;
         b3_up_ff    <= b2_up_ff;
         b3_err_ff   <= b2_err_ff;
      end
   end

   // ---------------- B4: B3 = ((raw << oss) + 2) / 4, toward zero ----------------
   logic [31:0] b4_v, b4_b3_ff, b4_xb_ff;
   logic [27:0] b4_t_ff;
   logic [23:0] b4_up_ff;
   logic        b4_err_ff;
   assign b4_v = (b3_b3raw_ff << oss_ff) + 32'd2;

   always_ff @(posedge clock) begin
      if (rb[4]) begin
         b4_b3_ff  <= $signed(b4_v + (b4_v[31] ? 32'd3 : 32'd0)) >>> 2;
         b4_xb_ff  <= b3_x3c_ff + XbOffset;
         b4_t_ff   <= b3_t_ff;
         b4_up_ff  <= b3_up_ff;
         b4_err_ff <= b3_err_ff;
      end
   end

   // ---------------- B5: B4 and B7 ----------------
   logic [31:0] b5_m4, b5_m7, b5_b7_ff;
   logic [16:0] b5_b4_ff;
   logic [27:0] b5_t_ff;
   logic        b5_err_ff;
   assign b5_m4 = {16'd0, ac4_ff} * b4_xb_ff;
   assign b5_m7 = ({8'd0, b4_up_ff} - b4_b3_ff) * {16'd0, press_scale(oss_ff)};

   always_ff @(posedge clock) begin
      if (rb[5]) begin
         b5_b4_ff  <= b5_m4[31:15];
         b5_b7_ff  <= b5_m7;
         b5_t_ff   <= b4_t_ff;
         b5_err_ff <= b4_err_ff;
      end
   end

   // B7 below 2^31 is doubled before the divide, otherwise the quotient is
   // doubled after it
   logic [31:0]     d2_dividend, d2_quot;
   logic [TagW-1:0] d2_tag_in, d2_tag;
   logic            b5_big;
   assign b5_big      = b5_b7_ff[31];
   assign d2_dividend = b5_big ? b5_b7_ff : {b5_b7_ff[30:0], 1'b0};
   assign d2_tag_in   = {28'd0, b5_big, b5_err_ff || (b5_b4_ff == '0), b5_t_ff};

   brc_div u_div_press (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (vb_ff[5]),
      .in_ready     (d2_in_ready),
      .in_dividend  (d2_dividend),
      .in_divisor   ({15'd0, b5_b4_ff}),
      .in_tag       (d2_tag_in),
      .out_valid    (d2_out_valid),
      .out_ready    (rc[0]),
      .out_quotient (d2_quot),
      .out_tag      (d2_tag)
   );

   // ---------------- C0: p, (p>>8)^2, -7357*p ----------------
   logic [31:0] c0_p, c0_s8, c0_sq, c0_mx, c0_p_ff, c0_sq_ff, c0_x2_ff;
   logic [27:0] c0_t_ff;
   logic        c0_err_ff;
   assign c0_p  = d2_tag[29] ? {d2_quot[30:0], 1'b0} : d2_quot;
   assign c0_s8 = $signed(c0_p) >>> 8;
   assign c0_sq = c0_s8 * c0_s8;
   assign c0_mx = CorrM7357 * c0_p;

   always_ff @(posedge clock) begin
      if (rc[0]) begin
         c0_p_ff   <= c0_p;
         c0_sq_ff  <= c0_sq;
         c0_x2_ff  <= $signed(c0_mx) >>> 16;
         c0_t_ff   <= d2_tag[27:0];
         c0_err_ff <= d2_tag[28];
      end
   end

   // ---------------- C1: x1 * 3038 >> 16 ----------------
   logic [31:0] c1_m, c1_x1_ff, c1_x2_ff, c1_p_ff;
   logic [27:0] c1_t_ff;
   logic        c1_err_ff;
   assign c1_m = c0_sq_ff * Corr3038;

   always_ff @(posedge clock) begin
      if (rc[1]) begin
         c1_x1_ff  <= $signed(c1_m) >>> 16;
         c1_x2_ff  <= c0_x2_ff;
         c1_p_ff   <= c0_p_ff;
         c1_t_ff   <= c0_t_ff;
         c1_err_ff <= c0_err_ff;
      end
   end

   // ---------------- C2: output register ----------------
   logic [31:0] c2_corr, c2_p_in, c2_p_ff;
   logic [27:0] c2_t_ff;
   logic        c2_err_ff;
   assign c2_corr = $signed(c1_x1_ff + c1_x2_ff + Corr3791) >>> 4;
   assign c2_p_in = c1_p_ff + c2_corr;

   always_ff @(posedge clock) begin
      if (rc[2]) begin
         c2_p_ff   <= c1_err_ff ? '0 : c2_p_in;
         c2_t_ff   <= c1_err_ff ? '0 : c1_t_ff;
         c2_err_ff <= c1_err_ff;
      end
   end

   assign rsp_tvalid = vc_ff[2];
   assign rsp_tdata  = {4'd0, c2_p_ff, c2_t_ff};
   assign rsp_tuser  = c2_err_ff;

   // ---------------- checks ----------------
   // an empty output stage means every stage can move, so input is open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output stage");

   // a divide error beat carries zero results
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("divide error beat with nonzero data");

   // an empty output stage stays empty unless the tail stage before it holds a beat
   a_no_shortcut: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && !vc_ff[1]) |=> !rsp_tvalid)
      else $error("output valid without upstream beat");

endmodule

// ----- tb/sv/barometer_raw_compensation_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometer_raw_compensation_unit_test
// Drives raw temperature/pressure beats through the compensation chain under
// several calibration sets and oversampling settings, predicts each result
// with a local integer model and compares every response beat field by field.
// ----------------------------------------------------------------------------
module barometer_raw_compensation_unit_test;
   import brc_pkg::*;

   localparam int Latency  = 76;
   localparam int MaxCycle = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_OSS;
   logic [31:0] csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic rsp_tuser;

   // shadow of the calibration set
   logic [1:0]  oss_q;
   logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q;
   logic [31:0] ac56_q, b12_q, mcmd_q;

   typedef struct packed {
      logic [27:0] temp;
      logic [31:0] press;
      logic        err;
   } comp_result_type;

   comp_result_type pending_results[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  idle_enable = 1'b1;

   barometer_raw_compensation_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MaxCycle) begin
         $display("[barometer_raw_compensation_unit] ERROR");
         $finish;
      end
   end

   function automatic logic signed [31:0] s16x(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // Signed 32-bit divide truncating toward zero (SV semantics match).
   function automatic comp_result_type compensate(input logic [15:0] ut,
                                                  input logic [23:0] bytes);
      comp_result_type r;
      logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
      logic signed [31:0] x1, x2, x3, d, b5, t, b6, sq, b3, p;
      logic [31:0] ac4, up, b4, b7, q, tmp;
      ac1 = s16x(ac1_q); ac2 = s16x(ac2_q); ac3 = s16x(ac3_q);
      ac4 = {16'd0, ac4_q};
      ac5 = {16'd0, ac56_q[31:16]}; ac6 = {16'd0, ac56_q[15:0]};
      b1 = s16x(b12_q[31:16]); b2 = s16x(b12_q[15:0]);
      mc = s16x(mcmd_q[31:16]); md = s16x(mcmd_q[15:0]);
      up = {8'd0, bytes} >> (4'd8 - oss_q);
      r = '0;
      r.err = 1'b1;
      x1 = ({16'd0, ut} - ac6) * ac5;
      x1 = x1 >>> 15;
      d = x1 + md;
      if (d == 0) return r;
      // mc*2048 fits in 32 bits, divisor nonzero; INT_MIN/-1 cannot occur
      x2 = (mc * 32'sd2048) / d;
      b5 = x1 + x2;
      t = (b5 + 32'sd8) >>> 4;
      b6 = b5 - 32'sd4000;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (ac2 * b6) >>> 11;
      x3 = x1 + x2;
      b3 = ac1 * 32'sd4 + x3;
      b3 = b3 << oss_q;
      b3 = (b3 + 32'sd2) / 32'sd4;
      x1 = (ac3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 32'sd2) >>> 2;
      tmp = x3 + 32'sd32768;
      b4 = (ac4 * tmp) >> 15;
      if (b4 == 0) return r;
      b7 = (up - b3) * ({16'd0, 16'd50000} >> oss_q);
      if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
      else q = (b7 / b4) * 32'd2;
      p = q;
      x1 = p >>> 8;
      x1 = x1 * x1;
      x1 = (x1 * 32'sd3038) >>> 16;
      x2 = (32'sh FFFF_E343 * p) >>> 16;
      p = p + ((x1 + x2 + 32'sd3791) >>> 4);
      r.temp = t[27:0];
      r.press = p;
      r.err = 1'b0;
      return r;
   endfunction

   // response checker and random back-pressure
   int rsp_hold = 0;
   always @(posedge clock) begin
      comp_result_type exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected response beat");
               fail_count++;
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_tdata[27:0] !== exp_r.temp) begin
                  $error("temperature_decicelsius exp %0h got %0h", exp_r.temp,
                         rsp_tdata[27:0]);
                  fail_count++;
               end
               if (rsp_tdata[59:28] !== exp_r.press) begin
                  $error("pressure_pa exp %0h got %0h", exp_r.press, rsp_tdata[59:28]);
                  fail_count++;
               end
               if (rsp_tuser !== exp_r.err) begin
                  $error("divide_error exp %0b got %0b", exp_r.err, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            // idle now, then draw a random hold count
            rsp_hold <= $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // csr_valid stays high between back-to-back writes; load_cal drops it
   task automatic write_csr(input csr_index_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_OSS:     oss_q = val[1:0];
         CSR_AC1:     ac1_q = val[15:0];
         CSR_AC2:     ac2_q = val[15:0];
         CSR_AC3:     ac3_q = val[15:0];
         CSR_AC4:     ac4_q = val[15:0];
         CSR_AC5_AC6: ac56_q = val;
         CSR_B1_B2:   b12_q = val;
         CSR_MC_MD:   mcmd_q = val;
         default: ;
      endcase
   endtask

   task automatic load_cal(input logic [1:0] oss, input logic [15:0] a1, a2, a3, a4,
                           input logic [31:0] a56, b12, mcmd);
      write_csr(CSR_OSS, {30'd0, oss});
      write_csr(CSR_AC1, {16'd0, a1});
      write_csr(CSR_AC2, {16'd0, a2});
      write_csr(CSR_AC3, {16'd0, a3});
      write_csr(CSR_AC4, {16'd0, a4});
      write_csr(CSR_AC5_AC6, a56);
      write_csr(CSR_B1_B2, b12);
      write_csr(CSR_MC_MD, mcmd);
      csr_valid <= 1'b0;
   endtask

   // One request beat, with an optional random gap in front of it.
   // req_tvalid stays high after the beat so the next one can follow directly.
   task automatic send_sample(input logic [15:0] ut, input logic [23:0] bytes);
      int gap;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {bytes, ut};
      pending_results.push_back(compensate(ut, bytes));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   task automatic send_random(input int n);
      repeat (n) send_sample(16'($urandom_range(0, 65535)),
                             24'($urandom_range(0, 24'hFFFFFF)));
   endtask

   // Calibration at reset is all zero: X1 + MD is zero, so every beat errors.
   task automatic test_reset_cal;
      send_sample(16'h0000, 24'h000000);
      send_sample(16'hFFFF, 24'hFFFFFF);
      drain();
   endtask

   // Typical datasheet coefficients, all oversampling settings, field extremes.
   task automatic test_nominal;
      for (int o = 0; o < 4; o++) begin
         load_cal(o[1:0], 16'd408, 16'hFFB9, 16'hC3AB, 16'd32741,
                  {16'd32757, 16'd23153}, {16'd6190, 16'd4}, {16'h8000, 16'd2868});
         send_sample(16'd27898, 24'h5D23_00 >> 0);
         send_sample(16'h0000, 24'h000000);
         send_sample(16'hFFFF, 24'hFFFFFF);
         send_sample(16'h5555, 24'hAAAAAA);
         send_sample(16'hAAAA, 24'h555555);
         drain();
      end
   endtask

   // Zero temperature divisor: AC5 zero makes X1 zero, MD zero.
   // Zero pressure divisor: AC4 zero forces B4 to zero.
   task automatic test_divide_errors;
      load_cal(2'd1, 16'd408, 16'd0, 16'd0, 16'd0, {16'd100, 16'd0}, 32'd0,
               {16'd5, 16'd1});
      send_sample(16'd1234, 24'h123456);
      drain();
      load_cal(2'd1, 16'd408, 16'd0, 16'd0, 16'd100, {16'd0, 16'd0}, 32'd0,
               {16'd5, 16'd0});
      send_sample(16'd1234, 24'h123456);
      drain();
   endtask

   // Extreme coefficients exercise wrap and the B7 high half split.
   task automatic test_extreme_cal;
      load_cal(2'd3, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF,
               32'h8000_7FFF, 32'h7FFF_8000);
      send_random(8);
      drain();
      load_cal(2'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 32'h0000_FFFF,
               32'h7FFF_8000, 32'h8000_7FFF);
      send_random(8);
      drain();
   endtask

   task automatic test_random;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7) idle_enable = 1'b0;
         load_cal(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
         send_random(45);
         drain();
      end
   endtask

   initial begin
      oss_q = '0; ac1_q = '0; ac2_q = '0; ac3_q = '0; ac4_q = '0;
      ac56_q = '0; b12_q = '0; mcmd_q = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_cal();
      test_nominal();
      test_divide_errors();
      test_extreme_cal();
      test_random();
      if (fail_count == 0) begin
         $display("[barometer_raw_compensation_unit] OK");
      end else begin
         $display("[barometer_raw_compensation_unit] ERROR");
      end
      $finish;
   end

endmodule
